[sv/ncp_pkg.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner package
// Shared widths, command opcodes, request and status codes, and the structs
// passed between the planner's decode, issue and top-level logic.
// ----------------------------------------------------------------------------
package ncp_pkg;

    // Default program page size in bytes (a power of two from 16 to 4096).
    localparam int unsigned DEF_PAGE_BYTES = 256;

    // Capacity register value after reset: 8 MB.
    localparam logic [31:0] CAPACITY_RESET = 32'd8388608;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_READ    = 2'd0,
        REQ_PROGRAM = 2'd1,
        REQ_ERASE   = 2'd2,
        REQ_NEXT    = 2'd3
    } req_type_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ARG_ERROR    = 2'd1,
        ST_NONE_PENDING = 2'd2
    } status_t;

    // Flash command opcodes.
    localparam logic [7:0] OP_NONE      = 8'h00;
    localparam logic [7:0] OP_READ      = 8'h0b;
    localparam logic [7:0] OP_PROGRAM   = 8'h02;
    localparam logic [7:0] OP_ERASE_4K  = 8'h20;
    localparam logic [7:0] OP_ERASE_32K = 8'h52;
    localparam logic [7:0] OP_ERASE_64K = 8'hd8;

    // Erase unit sizes in bytes and in 4 KB sectors.
    localparam logic [31:0] BYTES_4K     = 32'd4096;
    localparam logic [31:0] BYTES_32K    = 32'd32768;
    localparam logic [31:0] BYTES_64K    = 32'd65536;
    localparam logic [31:0] SECTORS_4K   = 32'd1;
    localparam logic [31:0] SECTORS_32K  = 32'd8;
    localparam logic [31:0] SECTORS_64K  = 32'd16;

    // Checked request: start address (sector aligned for an erase) and verdict.
    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
    } check_t;

    // Plan the issue logic works from: kind (0 program, 1 erase), address and
    // remaining amount (bytes for a program, sectors for an erase).
    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [31:0] remain;
    } plan_t;

    // One issued command and the plan left behind it.
    typedef struct packed {
        logic [7:0]  opcode;
        logic [31:0] byte_count;
        logic [31:0] next_addr;
        logic [31:0] next_remain;
        logic        last;
    } issue_t;

endpackage

[sv/ncp_if.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner channels
// Valid/ready channels for requests, issued commands and capacity writes.
// ----------------------------------------------------------------------------
interface ncp_req_if;
    import ncp_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [23:0] packed_address;
    logic [31:0] request_count;

    modport source (output valid, output req_type, output packed_address,
                    output request_count, input ready);
    modport sink (input valid, input req_type, input packed_address,
                  input request_count, output ready);
endinterface

interface ncp_res_if;
    import ncp_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  opcode;
    logic [31:0] flash_address;
    logic [31:0] byte_count;
    logic        needs_write_enable;
    logic        last;
    logic [1:0]  status;

    modport source (output valid, output opcode, output flash_address,
                    output byte_count, output needs_write_enable, output last,
                    output status, input ready);
    modport sink (input valid, input opcode, input flash_address,
                  input byte_count, input needs_write_enable, input last,
                  input status, output ready);
endinterface

interface ncp_cfg_if;
    import ncp_pkg::*;

    logic        valid;
    logic        ready;
    logic [31:0] flash_capacity;

    modport source (output valid, output flash_capacity, input ready);
    modport sink (input valid, input flash_capacity, output ready);
endinterface

[sv/ncp_check.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner request check
// Decodes the packed block/sector/page address to a byte address and checks
// the request's count and byte range against the flash capacity.
// ----------------------------------------------------------------------------
module ncp_check #(
    parameter int unsigned PAGE_BYTES = ncp_pkg::DEF_PAGE_BYTES
) (
    input  logic [1:0]      req_type,
    input  logic [23:0]     packed_address,
    input  logic [31:0]     request_count,
    input  logic [31:0]     flash_capacity,
    output ncp_pkg::check_t check
);
    import ncp_pkg::*;

    localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);

    logic [31:0] block_part;
    logic [31:0] sector_part;
    logic [31:0] page_part;
    logic [31:0] decoded;
    logic [31:0] start;
    logic [31:0] length;
    logic        is_erase;
    logic        count_ok;
    logic        range_ok;

    // Address decode; the sum wraps at 32 bits.
    assign block_part  = {packed_address[23:8], 16'h0000};
    assign sector_part = {16'h0000, packed_address[7:4], 12'h000};
    assign page_part   = 32'(packed_address[3:0]) << PAGE_W;
    assign decoded     = block_part + sector_part + page_part;

    // An erase starts on a 4 KB boundary and counts 4 KB sectors.
    assign is_erase = (req_type == REQ_ERASE);
    assign start    = is_erase ? {decoded[31:12], 12'h000} : decoded;
    assign length   = is_erase ? {request_count[19:0], 12'h000} : request_count;

    // A zero count is rejected, and an erase count must fit 20 bits.
    assign count_ok = (request_count != 32'd0) &&
                      (!is_erase || (request_count[31:20] == 12'h000));

    // The whole byte range must lie inside the flash.
    assign range_ok = (flash_capacity != 32'd0) && (start < flash_capacity) &&
                      (length <= (flash_capacity - start));

    assign check.ok   = count_ok && range_ok;
    assign check.addr = start;

endmodule

[sv/ncp_issue.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner command issue
// Picks the next command of a program or erase plan: a page program that
// stops at a page boundary, or the largest aligned erase unit that fits.
// ----------------------------------------------------------------------------
module ncp_issue #(
    parameter int unsigned PAGE_BYTES = ncp_pkg::DEF_PAGE_BYTES
) (
    input  ncp_pkg::plan_t  plan,
    output ncp_pkg::issue_t issue
);
    import ncp_pkg::*;

    localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);

    logic [PAGE_W-1:0] page_offset;
    logic [31:0]       room;
    logic [31:0]       chunk;
    logic [31:0]       units;
    logic [31:0]       step_bytes;
    logic [7:0]        erase_op;
    logic [31:0]       step_amount;
    logic [31:0]       remain_after;

    // Program: stop at the end of the current page.
    assign page_offset = plan.addr[PAGE_W-1:0];
    assign room        = 32'(PAGE_BYTES) - 32'(page_offset);
    assign chunk       = (plan.remain < room) ? plan.remain : room;

    // Erase: the largest unit aligned at this address that the count covers.
    always_comb
    begin
        if ((plan.addr[15:0] == 16'h0000) && (plan.remain >= SECTORS_64K))
        begin
            erase_op   = OP_ERASE_64K;
            units      = SECTORS_64K;
            step_bytes = BYTES_64K;
        end
        else if ((plan.addr[14:0] == 15'h0000) && (plan.remain >= SECTORS_32K))
        begin
            erase_op   = OP_ERASE_32K;
            units      = SECTORS_32K;
            step_bytes = BYTES_32K;
        end
        else
        begin
            erase_op   = OP_ERASE_4K;
            units      = SECTORS_4K;
            step_bytes = BYTES_4K;
        end
    end

    // Advance the plan by the chosen step.
    assign step_amount  = plan.kind ? units : chunk;
    assign remain_after = plan.remain - step_amount;

    assign issue.opcode      = plan.kind ? erase_op : OP_PROGRAM;
    assign issue.byte_count  = plan.kind ? step_bytes : chunk;
    assign issue.next_addr   = plan.addr + (plan.kind ? step_bytes : chunk);
    assign issue.next_remain = remain_after;
    assign issue.last        = (remain_after == 32'd0);

endmodule

[sv/nor_flash_command_planner.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner
// Turns read, program and erase requests into SPI NOR commands, one command
// per item, with a pending plan that "next" items step through.
// ----------------------------------------------------------------------------
// The accepting edge loads the input register; the result register then
// loads once it is empty or being emptied, and offers the result.
// Throughput: one item per cycle unless the command side stalls. Plan
// and result registers load together, so a "next" item may follow directly.
// Reset: the plan is cleared and the capacity register returns to 8 MB.
module nor_flash_command_planner #(
    parameter int unsigned PAGE_BYTES = ncp_pkg::DEF_PAGE_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    ncp_req_if.sink   req,
    ncp_res_if.source res,
    ncp_cfg_if.sink   cfg
);
    import ncp_pkg::*;

    // Capacity register.
    logic [31:0] capacity_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_type_reg;
    logic [23:0] in_address_reg;
    logic [31:0] in_count_reg;

    // Plan registers.
    logic        plan_active_reg, plan_active_next;
    logic        plan_kind_reg, plan_kind_next;
    logic [31:0] plan_addr_reg, plan_addr_next;
    logic [31:0] plan_remain_reg, plan_remain_next;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  out_opcode_reg, out_opcode_next;
    logic [31:0] out_address_reg, out_address_next;
    logic [31:0] out_count_reg, out_count_next;
    logic        out_wen_reg, out_wen_next;
    logic        out_last_reg, out_last_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic    advance;
    logic    in_take;
    logic    is_next;
    check_t  check;
    plan_t   plan_src;
    issue_t  issue;

    // Handshake: the input register moves on whenever the result register
    // is empty or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    ncp_check #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_check (
        .req_type       (in_type_reg),
        .packed_address (in_address_reg),
        .request_count  (in_count_reg),
        .flash_capacity (capacity_reg),
        .check          (check)
    );

    // A new request starts a fresh plan; a next item continues the stored one.
    assign is_next = (in_type_reg == REQ_NEXT);

    always_comb
    begin
        if (is_next)
        begin
            plan_src.kind   = plan_kind_reg;
            plan_src.addr   = plan_addr_reg;
            plan_src.remain = plan_remain_reg;
        end
        else
        begin
            plan_src.kind   = (in_type_reg == REQ_ERASE);
            plan_src.addr   = check.addr;
            plan_src.remain = in_count_reg;
        end
    end

    ncp_issue #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_issue (
        .plan  (plan_src),
        .issue (issue)
    );

    // Result and plan update for the item in the input register.
    always_comb
    begin
        plan_active_next = plan_active_reg;
        plan_kind_next   = plan_kind_reg;
        plan_addr_next   = plan_addr_reg;
        plan_remain_next = plan_remain_reg;
        out_opcode_next  = OP_NONE;
        out_address_next = 32'd0;
        out_count_next   = 32'd0;
        out_wen_next     = 1'b0;
        out_last_next    = 1'b0;
        out_status_next  = ST_ARG_ERROR;

        if (is_next)
        begin
            if (plan_active_reg)
            begin
                out_opcode_next  = issue.opcode;
                out_address_next = plan_src.addr;
                out_count_next   = issue.byte_count;
                out_wen_next     = 1'b1;
                out_last_next    = issue.last;
                out_status_next  = ST_OK;
                plan_addr_next   = issue.next_addr;
                plan_remain_next = issue.next_remain;
                plan_active_next = !issue.last;
            end
            else
            begin
                out_status_next = ST_NONE_PENDING;
            end
        end
        else
        begin
            // Any new request drops the pending plan.
            plan_active_next = 1'b0;
            plan_remain_next = 32'd0;
            if (check.ok)
            begin
                out_status_next  = ST_OK;
                out_address_next = check.addr;
                if (in_type_reg == REQ_READ)
                begin
                    out_opcode_next = OP_READ;
                    out_count_next  = in_count_reg;
                    out_last_next   = 1'b1;
                end
                else
                begin
                    out_opcode_next  = issue.opcode;
                    out_count_next   = issue.byte_count;
                    out_wen_next     = 1'b1;
                    out_last_next    = issue.last;
                    plan_kind_next   = plan_src.kind;
                    plan_addr_next   = issue.next_addr;
                    plan_remain_next = issue.next_remain;
                    plan_active_next = !issue.last;
                end
            end
        end
    end

    // Control state: valid flags, plan and capacity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            plan_active_reg <= 1'b0;
            plan_kind_reg   <= 1'b0;
            plan_addr_reg   <= 32'd0;
            plan_remain_reg <= 32'd0;
            capacity_reg    <= CAPACITY_RESET;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                plan_active_reg <= plan_active_next;
                plan_kind_reg   <= plan_kind_next;
                plan_addr_reg   <= plan_addr_next;
                plan_remain_reg <= plan_remain_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                capacity_reg <= cfg.flash_capacity;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_type_reg    <= req.req_type;
            in_address_reg <= req.packed_address;
            in_count_reg   <= req.request_count;
        end
        if (advance)
        begin
            out_opcode_reg  <= out_opcode_next;
            out_address_reg <= out_address_next;
            out_count_reg   <= out_count_next;
            out_wen_reg     <= out_wen_next;
            out_last_reg    <= out_last_next;
            out_status_reg  <= out_status_next;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.opcode             = out_opcode_reg;
    assign res.flash_address      = out_address_reg;
    assign res.byte_count         = out_count_reg;
    assign res.needs_write_enable = out_wen_reg;
    assign res.last               = out_last_reg;
    assign res.status             = out_status_reg;

endmodule

[sv/ncp_checker.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner checker
// Checks the issued commands seen on the result channel.
// ----------------------------------------------------------------------------
module ncp_checker #(
    parameter int unsigned PAGE_BYTES = ncp_pkg::DEF_PAGE_BYTES
) (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  opcode,
    input logic [31:0] flash_address,
    input logic [31:0] byte_count,
    input logic        needs_write_enable,
    input logic        last,
    input logic [1:0]  status
);
    import ncp_pkg::*;

    localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(opcode) &&
        $stable(flash_address) && $stable(byte_count) && $stable(status))
    else $error("result changed while stalled");

    // A failed item carries no command.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_OK) |-> (opcode == OP_NONE) &&
        (flash_address == 32'd0) && (byte_count == 32'd0) &&
        !needs_write_enable && !last)
    else $error("error result carries command fields");

    // A read is a single command without write enable.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_OK) && (opcode == OP_READ) |->
        last && !needs_write_enable)
    else $error("read command flags wrong");

    // A page program never crosses a page boundary.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_OK) && (opcode == OP_PROGRAM) |->
        needs_write_enable && (byte_count != 32'd0) &&
        (((flash_address & PAGE_MASK) + byte_count) <= 32'(PAGE_BYTES)))
    else $error("page program crosses a page boundary");

    // Each erase unit is aligned and sized to its opcode.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_OK) && (opcode != OP_READ) &&
        (opcode != OP_PROGRAM) |->
        ((opcode == OP_ERASE_64K) && (byte_count == BYTES_64K) &&
         (flash_address[15:0] == 16'h0000)) ||
        ((opcode == OP_ERASE_32K) && (byte_count == BYTES_32K) &&
         (flash_address[14:0] == 15'h0000)) ||
        ((opcode == OP_ERASE_4K) && (byte_count == BYTES_4K) &&
         (flash_address[11:0] == 12'h000)))
    else $error("erase unit misaligned or mis-sized");

endmodule

bind nor_flash_command_planner ncp_checker #(
    .PAGE_BYTES (PAGE_BYTES)
) u_ncp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .opcode             (res.opcode),
    .flash_address      (res.flash_address),
    .byte_count         (res.byte_count),
    .needs_write_enable (res.needs_write_enable),
    .last               (res.last),
    .status             (res.status)
);

[tb/sv/ncp_command_checker.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner checker
// Watches the request, command and capacity channels. It keeps its own copy
// of the capacity register and of the pending plan, works out the command that
// each accepted request item should produce, and compares every accepted
// command item with the oldest planned one, field by field.
// ----------------------------------------------------------------------------
module ncp_command_checker #(
    parameter int unsigned PAGE_BYTES = ncp_pkg::DEF_PAGE_BYTES
) (
    input  logic clk,
    input  logic rst_n,
    ncp_req_if   req,
    ncp_res_if   res,
    ncp_cfg_if   cfg,
    output int   cmd_errors,
    output int   cmds_pending
);
    import ncp_pkg::*;

    // Largest sector count whose byte length still fits in 32 bits.
    localparam logic [31:0] MAX_ERASE_SECTORS = 32'h000f_ffff;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [31:0] flash_address;
        logic [31:0] byte_count;
        logic        needs_write_enable;
        logic        last;
        status_t     status;
    } flash_cmd_t;

    // Local copy of the capacity register and the pending plan.
    logic [31:0] capacity;
    logic        plan_open;
    logic        plan_is_erase;
    logic [31:0] plan_addr;
    logic [31:0] plan_left;

    flash_cmd_t  planned_cmds[$];
    int          cmds_seen;

    // A rejected request or an empty pull carries only its status.
    function automatic flash_cmd_t rejected(input status_t why);
        flash_cmd_t cmd;
        cmd = '0;
        cmd.status = why;
        return cmd;
    endfunction

    function automatic bit fits_capacity(input logic [31:0] start, input logic [31:0] len);
        if (capacity == 32'd0 || start >= capacity)
            return 1'b0;
        return len <= capacity - start;
    endfunction

    // Take one command off the pending plan and advance the plan.
    function automatic flash_cmd_t issue_from_plan();
        flash_cmd_t  cmd;
        logic [31:0] room;
        logic [31:0] chunk;
        logic [31:0] units;
        cmd = '0;
        cmd.flash_address      = plan_addr;
        cmd.needs_write_enable = 1'b1;
        cmd.status             = ST_OK;
        if (!plan_is_erase)
        begin
            // Page program never crosses a page boundary.
            room  = PAGE_BYTES - (plan_addr % PAGE_BYTES);
            chunk = (plan_left < room) ? plan_left : room;
            cmd.opcode     = OP_PROGRAM;
            cmd.byte_count = chunk;
            plan_addr      = plan_addr + chunk;
            plan_left      = plan_left - chunk;
        end
        else
        begin
            // Largest aligned erase unit that the remaining count still covers.
            if (plan_addr[15:0] == 16'd0 && plan_left >= SECTORS_64K)
            begin
                cmd.opcode = OP_ERASE_64K;
                units      = SECTORS_64K;
            end
            else if (plan_addr[14:0] == 15'd0 && plan_left >= SECTORS_32K)
            begin
                cmd.opcode = OP_ERASE_32K;
                units      = SECTORS_32K;
            end
            else
            begin
                cmd.opcode = OP_ERASE_4K;
                units      = SECTORS_4K;
            end
            cmd.byte_count = units * BYTES_4K;
            plan_addr      = plan_addr + units * BYTES_4K;
            plan_left      = plan_left - units;
        end
        plan_open = (plan_left != 32'd0);
        cmd.last  = !plan_open;
        return cmd;
    endfunction

    // Command expected for one accepted request item.
    function automatic flash_cmd_t plan_command(input req_type_t kind,
                                                input logic [23:0] pk_addr,
                                                input logic [31:0] count);
        logic [31:0] start;
        flash_cmd_t  cmd;
        if (kind == REQ_NEXT)
            return plan_open ? issue_from_plan() : rejected(ST_NONE_PENDING);

        // Any new request drops the pending plan, accepted or not.
        plan_open = 1'b0;
        plan_left = 32'd0;
        start = {pk_addr[23:8], 16'h0000} + 32'(pk_addr[7:4]) * BYTES_4K
                + 32'(pk_addr[3:0]) * PAGE_BYTES;

        if (kind == REQ_READ)
        begin
            if (count == 32'd0 || !fits_capacity(start, count))
                return rejected(ST_ARG_ERROR);
            cmd = '0;
            cmd.opcode        = OP_READ;
            cmd.flash_address = start;
            cmd.byte_count    = count;
            cmd.last          = 1'b1;
            cmd.status        = ST_OK;
            return cmd;
        end

        if (kind == REQ_PROGRAM)
        begin
            if (count == 32'd0 || !fits_capacity(start, count))
                return rejected(ST_ARG_ERROR);
            plan_is_erase = 1'b0;
        end
        else
        begin
            // An erase starts on the 4 KB sector that holds the address.
            start[11:0] = 12'd0;
            if (count == 32'd0 || count > MAX_ERASE_SECTORS
                || !fits_capacity(start, count * BYTES_4K))
                return rejected(ST_ARG_ERROR);
            plan_is_erase = 1'b1;
        end
        plan_addr = start;
        plan_left = count;
        plan_open = 1'b1;
        return issue_from_plan();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: command %0d %s: got %0h, expected %0h",
                 $time, cmds_seen, what, got, want);
        cmd_errors++;
    endtask

    // Track register writes, compare commands, then predict for new requests.
    always @(posedge clk)
    begin
        flash_cmd_t got;
        flash_cmd_t want;
        if (!rst_n)
        begin
            capacity      = CAPACITY_RESET;
            plan_open     = 1'b0;
            plan_is_erase = 1'b0;
            plan_addr     = 32'd0;
            plan_left     = 32'd0;
            planned_cmds.delete();
            cmds_seen     = 0;
            cmd_errors    = 0;
            cmds_pending  = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                capacity = cfg.flash_capacity;

            if (res.valid && res.ready)
            begin
                got.opcode             = res.opcode;
                got.flash_address      = res.flash_address;
                got.byte_count         = res.byte_count;
                got.needs_write_enable = res.needs_write_enable;
                got.last               = res.last;
                got.status             = status_t'(res.status);
                if (planned_cmds.size() == 0)
                    report_mismatch("arrived with none outstanding, opcode",
                                    32'(got.opcode), 32'd0);
                else
                begin
                    want = planned_cmds.pop_front();
                    if (got.opcode !== want.opcode)
                        report_mismatch("opcode", 32'(got.opcode), 32'(want.opcode));
                    if (got.flash_address !== want.flash_address)
                        report_mismatch("flash_address", got.flash_address,
                                        want.flash_address);
                    if (got.byte_count !== want.byte_count)
                        report_mismatch("byte_count", got.byte_count, want.byte_count);
                    if (got.needs_write_enable !== want.needs_write_enable)
                        report_mismatch("needs_write_enable",
                                        32'(got.needs_write_enable),
                                        32'(want.needs_write_enable));
                    if (got.last !== want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
                cmds_seen++;
            end

            if (req.valid && req.ready)
                planned_cmds.push_back(plan_command(req_type_t'(req.req_type),
                                                    req.packed_address,
                                                    req.request_count));
            cmds_pending = planned_cmds.size();
        end
    end

endmodule

[tb/sv/tb_nor_flash_command_planner.sv]
// ----------------------------------------------------------------------------
// NOR flash command planner testbench
// Drives request items and capacity writes into the planner, with random
// gaps on the request side and random stalls on the command side, including
// a long hold-off that backs the block up. A directed opening covers field
// extremes and each corner of the planning rules; random phases then run
// request-and-pull sequences under several capacity settings. The checker
// beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_nor_flash_command_planner;
    import ncp_pkg::*;

    localparam int unsigned PAGE        = DEF_PAGE_BYTES;
    localparam int          IDLE_PCT    = 27;
    localparam int          HOLD_CYCLES = 200;
    localparam int          PHASE_ITEMS = 130;
    localparam int          NUM_PHASES  = 6;

    logic clk;
    logic rst_n;

    ncp_req_if req_ch ();
    ncp_res_if res_ch ();
    ncp_cfg_if cfg_ch ();

    int          cmd_errors;
    int          cmds_pending;
    logic [31:0] capacity_now;
    bit          steady = 1'b0;
    int          holdoff_asked = 0;

    nor_flash_command_planner #(.PAGE_BYTES(PAGE)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    ncp_command_checker #(.PAGE_BYTES(PAGE)) cmd_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .res          (res_ch),
        .cfg          (cfg_ch),
        .cmd_errors   (cmd_errors),
        .cmds_pending (cmds_pending)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Command side: random stalls, plus one long hold-off per request.
    initial
    begin
        int served;
        served = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_asked > served)
            begin
                served++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offer one request item and wait until it is accepted.
    task automatic push_request(input req_type_t kind, input logic [23:0] pk_addr,
                                input logic [31:0] count);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.packed_address <= pk_addr;
        req_ch.request_count  <= count;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every planned command has come out.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (cmds_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [31:0] value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.flash_capacity <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        capacity_now = value;
    endtask

    // Packed address whose 64 KB block lies below the current capacity.
    function automatic logic [23:0] pick_address();
        logic [31:0] top_block;
        top_block = (capacity_now == 32'd0) ? 32'd0 : ((capacity_now - 32'd1) >> 16);
        if (top_block > 32'h0000_ffff)
            top_block = 32'h0000_ffff;
        return {16'($urandom_range(0, top_block)), 8'($urandom)};
    endfunction

    // Mostly a request followed by pulls, sometimes raw noise.
    task automatic random_phase(input int items);
        int          sent;
        int          pulls;
        int          pick;
        req_type_t   kind;
        logic [23:0] pk_addr;
        logic [31:0] count;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                push_request(req_type_t'($urandom_range(0, 3)), 24'($urandom), $urandom);
                sent++;
            end
            else
            begin
                pick    = $urandom_range(0, 4);
                pk_addr = pick_address();
                if (pick == 0)
                begin
                    kind = REQ_READ;
                    case ($urandom_range(0, 9))
                        0:       count = 32'd0;
                        1:       count = $urandom;
                        2:       count = capacity_now;
                        default: count = $urandom_range(1, 4096);
                    endcase
                end
                else if (pick <= 2)
                begin
                    kind = REQ_PROGRAM;
                    case ($urandom_range(0, 11))
                        0:       count = 32'd0;
                        1:       count = $urandom;
                        2:       count = $urandom_range(1, PAGE);
                        default: count = $urandom_range(1, 1300);
                    endcase
                end
                else
                begin
                    kind = REQ_ERASE;
                    // Favor 64 KB and 32 KB aligned starts.
                    if ($urandom_range(0, 99) < 30)
                        pk_addr[7:4] = $urandom_range(0, 1) ? 4'd8 : 4'd0;
                    case ($urandom_range(0, 11))
                        0:       count = 32'd0;
                        1:       count = $urandom_range(0, 1) ? 32'h000f_ffff : 32'h0010_0000;
                        2:       count = $urandom;
                        3:       count = $urandom_range(1, 300);
                        default: count = $urandom_range(1, 40);
                    endcase
                end
                push_request(kind, pk_addr, count);
                sent++;
                pulls = $urandom_range(0, 12);
                repeat (pulls)
                begin
                    push_request(REQ_NEXT, 24'($urandom), $urandom);
                    sent++;
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [31:0] phase_caps[NUM_PHASES];
        phase_caps[0] = 32'd0;
        phase_caps[1] = 32'hffff_ffff;
        phase_caps[2] = 32'h0010_0000;
        phase_caps[3] = $urandom_range(1, 32'h0200_0000);
        phase_caps[4] = 32'd1;
        phase_caps[5] = CAPACITY_RESET;
        capacity_now  = CAPACITY_RESET;

        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_READ;
        req_ch.packed_address <= 24'd0;
        req_ch.request_count  <= 32'd0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.flash_capacity <= 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset capacity of 8 MB.
        push_request(REQ_NEXT, 24'hff_ffff, 32'hffff_ffff);    // nothing pending
        push_request(REQ_READ, 24'h00_0000, 32'd1);
        push_request(REQ_READ, 24'h00_0123, 32'd0);            // zero count
        push_request(REQ_READ, 24'h00_0000, 32'h0080_0000);    // whole flash
        push_request(REQ_READ, 24'h00_8000, 32'd1);            // start at capacity
        push_request(REQ_READ, 24'h00_7fff, 32'd256);          // last page exactly
        push_request(REQ_READ, 24'h00_7fff, 32'd257);          // one byte past the end
        push_request(REQ_READ, 24'hff_ffff, 32'hffff_ffff);
        push_request(REQ_PROGRAM, 24'h00_0105, 32'd600);       // three page chunks
        push_request(REQ_NEXT, 24'h00_0000, 32'd0);
        push_request(REQ_NEXT, 24'h00_0000, 32'd0);
        push_request(REQ_NEXT, 24'h00_0000, 32'd0);            // plan already done
        push_request(REQ_PROGRAM, 24'h00_0200, 32'd0);         // zero count
        push_request(REQ_ERASE, 24'h00_001f, 32'd40);          // unaligned start, mixed units
        repeat (4) push_request(REQ_NEXT, 24'h00_0000, 32'd0);
        push_request(REQ_READ, 24'h00_0001, 32'd16);           // drops the erase plan
        push_request(REQ_NEXT, 24'h00_0000, 32'd0);
        push_request(REQ_ERASE, 24'h00_0000, 32'h0010_0000);   // sector count too large
        push_request(REQ_ERASE, 24'h00_0000, 32'd0);
        push_request(REQ_ERASE, 24'h00_0000, 32'd128);         // first 512 KB in 64 KB units
        push_request(REQ_NEXT, 24'h00_0000, 32'd0);
        push_request(REQ_PROGRAM, 24'h00_0000, 32'hffff_ffff); // beyond capacity
        drain();

        // Random phases, each under its own capacity setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            steady = (p == 2);
            if (p == 1 || p == 4)
                holdoff_asked++;
            // Top-of-range requests against the new capacity.
            push_request(REQ_ERASE, 24'h00_0000, 32'h000f_ffff);
            push_request(REQ_NEXT, 24'h00_0000, 32'd0);
            push_request(REQ_READ, 24'hff_ffff, 32'd255);
            push_request(REQ_PROGRAM, 24'hff_ffff, 32'd255);
            push_request(REQ_NEXT, 24'h00_0000, 32'd0);
            random_phase(PHASE_ITEMS);
            drain();
        end

        if (cmd_errors == 0 && cmds_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
